/* rtl/crcsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcsp_pkg
// Shared types, constants and helpers of the selectable-polynomial CRC block.
// ----------------------------------------------------------------------------
package crcsp_pkg;

  // Widest generator degree and remainder width.
  localparam int MAX_DEGREE = 64;
  // Width of the degree register.
  localparam int DEG_W      = 7;
  // Bit steps per message byte.
  localparam int STEPS      = 8;
  // Configuration data and address widths.
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = 4;

  // Register indexes, decoded from the 8-byte slot number of the address.
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_POLY   = 1'b1;

  // Reset values: CRC-32 generator.
  localparam logic [DEG_W-1:0]      DEGREE_RESET = DEG_W'(32);
  localparam logic [MAX_DEGREE-1:0] POLY_RESET   = MAX_DEGREE'(64'h0000_0000_8260_8EDB);

  // Control broadcast to every cell of the remainder row.
  typedef struct packed {
    logic step;   // a byte is accepted: take the result of the eight steps
    logic clear;  // the byte closes the message: the remainder returns to zero
    logic load;   // degree changed: take the realigned remainder
  } cell_ctl_t;

  // Realignment request from the register block on a degree write.
  typedef struct packed {
    logic             realign;
    logic [DEG_W-1:0] new_shift;
  } realign_t;

  // Degree in force: zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] n;
    n = deg;
    if (n == '0) begin
      n = DEG_W'(1);
    end else if (n > DEG_W'(MAX_DEGREE)) begin
      n = DEG_W'(MAX_DEGREE);
    end
    return n;
  endfunction

  // The remainder is kept left-justified; this is its distance from bit zero.
  function automatic logic [DEG_W-1:0] align_shift(input logic [DEG_W-1:0] deg);
    return DEG_W'(MAX_DEGREE) - eff_degree(deg);
  endfunction

endpackage

/* rtl/crcsp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcsp_cell
// One bit slice of the left-justified remainder. It passes its value through
// the eight bit steps of a byte and hands each intermediate bit to the cell
// above it.
// ----------------------------------------------------------------------------
module crcsp_cell import crcsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             load_bit,   // realigned remainder bit
  input  logic             gen_bit,    // aligned generator bit of this slice
  input  logic [STEPS-1:0] fb,         // feedback of each bit step
  input  logic [STEPS-1:0] chain_in,   // lower neighbor before each step
  output logic [STEPS-1:0] chain_out,  // this slice before each step
  output logic             next_bit    // this slice after the last step
);

  logic           bit_r;
  logic           bit_nxt;
  logic [STEPS:0] st;

  // Each step shifts in the lower neighbor and adds the generator on feedback.
  always_comb begin
    st[0] = bit_r;
    for (int s = 0; s < STEPS; s++) begin
      st[s+1] = chain_in[s] ^ (fb[s] & gen_bit);
    end
  end

  assign chain_out = st[STEPS-1:0];
  assign next_bit  = st[STEPS];

  // Next value of the stored bit.
  always_comb begin
    priority if (ctl.load) begin
      bit_nxt = load_bit;
    end else if (ctl.clear) begin
      bit_nxt = 1'b0;
    end else if (ctl.step) begin
      bit_nxt = st[STEPS];
    end else begin
      bit_nxt = bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

endmodule

/* rtl/crcsp_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcsp_regs
// Configuration registers: degree and generator polynomial, with a
// realignment request for the remainder whenever the degree is written.
// ----------------------------------------------------------------------------
module crcsp_regs import crcsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready,
  output logic [DEG_W-1:0]      shift_cur,
  output logic [MAX_DEGREE-1:0] poly,
  output realign_t              realign
);

  logic [DEG_W-1:0]      degree_r;
  logic [DEG_W-1:0]      degree_nxt;
  logic [MAX_DEGREE-1:0] poly_r;
  logic [MAX_DEGREE-1:0] poly_nxt;
  logic                  wr_en;
  logic                  reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // Each register owns an 8-byte slot; the byte offset within it is ignored.
  assign reg_sel    = cfg_paddr[3];

  // Register writes.
  always_comb begin
    degree_nxt = degree_r;
    poly_nxt   = poly_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEGREE: degree_nxt = cfg_pwdata[DEG_W-1:0];
        REG_POLY:   poly_nxt   = cfg_pwdata[MAX_DEGREE-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
      poly_r   <= POLY_RESET;
    end else begin
      degree_r <= degree_nxt;
      poly_r   <= poly_nxt;
    end
  end

  // Read-back.
  always_comb begin
    unique case (reg_sel)
      REG_DEGREE: cfg_prdata = CFG_DW'(degree_r);
      REG_POLY:   cfg_prdata = CFG_DW'(poly_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign shift_cur         = align_shift(degree_r);
  assign poly              = poly_r;
  assign realign.realign   = wr_en && (reg_sel == REG_DEGREE);
  assign realign.new_shift = align_shift(cfg_pwdata[DEG_W-1:0]);

endmodule

/* rtl/crc_selectable_polynomial.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_selectable_polynomial
// MSB-first CRC of a byte stream with a programmable generator of degree
// 1 to 64, zero initial value, no reflection and no final XOR.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a result waits; the eight bit steps
//   of a byte ripple through the 64 remainder cells and the top cell's feedback.
// Result: the word for a byte marked last appears in the cycle after acceptance.
// The output register decouples the sides: a byte is taken while a result waits
//   if the result is taken in the same cycle.
// Reset: synchronous, active low; remainder and output valid clear, degree
//   returns to 32 and the polynomial to 0x82608EDB.
// ----------------------------------------------------------------------------
module crc_selectable_polynomial import crcsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] data_byte
  input  logic              in_tlast,    // last_byte
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,   // [63:0] crc_value
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [DEG_W-1:0]      shift_cur;
  logic [MAX_DEGREE-1:0] poly;
  realign_t              realign;
  logic                  in_acc;
  cell_ctl_t             ctl;
  logic [MAX_DEGREE-1:0] gen_left;
  logic [MAX_DEGREE-1:0] rem_vec;
  logic [MAX_DEGREE-1:0] next_vec;
  logic [MAX_DEGREE-1:0] load_vec;
  logic [MAX_DEGREE-1:0] step_rem;
  logic [MAX_DEGREE-1:0] rem_base_r;
  logic [MAX_DEGREE-1:0] rem_base_nxt;
  logic [STEPS-1:0]      chain [MAX_DEGREE];
  logic [STEPS-1:0]      data_rev;
  logic [STEPS-1:0]      fb;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [63:0]           out_data_r;

  crcsp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .shift_cur   (shift_cur),
    .poly        (poly),
    .realign     (realign)
  );

  // A byte is taken whenever the output register is free or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign ctl.step  = in_acc;
  assign ctl.clear = in_acc && in_tlast;
  assign ctl.load  = realign.realign;

  // Generator with the implied +1, aligned to the top of the remainder.
  assign gen_left = {poly[MAX_DEGREE-2:0], 1'b1} << shift_cur;

  // Data bits in step order: the most significant bit goes first.
  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      data_rev[s] = in_tdata[STEPS-1-s];
    end
  end

  // Feedback of each step is the top cell XOR that step's data bit.
  assign fb = chain[MAX_DEGREE-1] ^ data_rev;

  // Remainder after the eight steps, moved down to bit zero.
  assign step_rem = next_vec >> shift_cur;

  // The remainder as it stood after the last byte, kept at full width so
  // that a degree lowered and raised again between bytes loses nothing.
  always_comb begin
    priority if (ctl.clear) begin
      rem_base_nxt = '0;
    end else if (ctl.step) begin
      rem_base_nxt = step_rem;
    end else begin
      rem_base_nxt = rem_base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_base_r <= '0;
    end else begin
      rem_base_r <= rem_base_nxt;
    end
  end

  // On a degree write the row takes that remainder at the new alignment;
  // bits above the new degree fall off the top of the row.
  assign load_vec = rem_base_r << realign.new_shift;

  // Row of remainder cells, bit zero at the bottom.
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    logic [STEPS-1:0] lower;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_link
      assign lower = chain[i-1];
    end
    crcsp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_bit  (load_vec[i]),
      .gen_bit   (gen_left[i]),
      .fb        (fb),
      .chain_in  (lower),
      .chain_out (chain[i]),
      .next_bit  (next_vec[i])
    );
    assign rem_vec[i] = chain[i][0];
  end

  // Output register.
  always_comb begin
    priority if (in_acc && in_tlast) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The final remainder is shifted down to bit zero.
  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_data_r <= step_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A closing byte yields a word in the next cycle.
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid)
    else $error("no result word after a closing byte");

  // A closing byte leaves the remainder cleared unless a degree write comes with it.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast && !realign.realign |=> rem_vec == '0)
    else $error("remainder not cleared after a closing byte");

  // Bits below the alignment of the degree stay zero.
  a_low_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_vec & ~({MAX_DEGREE{1'b1}} << shift_cur)) == '0)
    else $error("remainder bits below the degree alignment are set");

  // Input stalls only behind a waiting word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the selectable-polynomial CRC block against a bit-serial predictor.
// Directed messages cover the standard CRC-32 check string, every listed
// generator, the clamping of out-of-range degrees, polynomial bits above the
// degree and a degree change in the middle of a message. Back-pressure and
// about 1600 random bytes follow, with the configuration changed between
// phases. Every CRC word is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import crcsp_pkg::*;

  localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 4;     // settling time after the last result
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int RANDOM_ITEMS = 1600;

  // Generators from the usual tables, with x^n included and +1 implied.
  localparam logic [63:0] KNOWN_POLY [8] = '{
    64'h1, 64'h5, 64'h9, 64'h12, 64'hD3, 64'h8810, 64'h82608EDB, 64'h800000000000000D
  };
  localparam logic [DEG_W-1:0] KNOWN_DEGREE [8] = '{
    DEG_W'(1), DEG_W'(3), DEG_W'(4), DEG_W'(5), DEG_W'(8), DEG_W'(16), DEG_W'(32),
    DEG_W'(64)
  };
  localparam logic [DEG_W-1:0] CORNER_DEGREE [10] = '{
    DEG_W'(0), DEG_W'(1), DEG_W'(2), DEG_W'(8), DEG_W'(16), DEG_W'(32), DEG_W'(63),
    DEG_W'(64), DEG_W'(65), DEG_W'(127)
  };

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;   // [7:0] data_byte
  logic              in_tlast    = 1'b0; // last_byte
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [63:0]       out_tdata;          // [63:0] crc_value
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predictor state: configuration copy, running remainder, pending CRCs.
  logic [DEG_W-1:0]  shadow_degree = DEG_W'(32);
  logic [63:0]       shadow_poly   = 64'h82608EDB;
  logic [63:0]       crc_remainder = '0;
  logic [63:0]       crc_expected [$];

  int                mismatch_count = 0;
  int                items_sent     = 0;
  int                quiet_cycles   = 0;
  bit                tx_gaps        = 1'b0;
  bit                rx_stalls      = 1'b0;
  bit                hold_token     = 1'b0;
  bit                hold_seen      = 1'b0;
  int                hold_left      = 0;

  crc_selectable_polynomial i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One byte of long division, MSB first, at the degree and generator given.
  function automatic logic [63:0] divide_byte(input logic [63:0] rem_in,
                                              input logic [7:0] data,
                                              input logic [DEG_W-1:0] degree,
                                              input logic [63:0] poly);
    int unsigned n;
    logic [63:0] mask;
    logic [63:0] gen;
    logic [63:0] rem;
    logic        fb;
    int          b;
    n = degree;
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_DEGREE) begin
      n = MAX_DEGREE;
    end
    mask = (n == 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    gen  = ((poly << 1) | 64'd1) & mask;
    rem  = rem_in & mask;
    for (b = 7; b >= 0; b--) begin
      fb  = rem[n-1] ^ data[b];
      rem = (rem << 1) & mask;
      if (fb) begin
        rem = rem ^ gen;
      end
    end
    return rem;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Result words are checked first, then an accepted byte updates the
  // prediction, so both sides seen at one edge give the same answer.
  always @(posedge clk) begin
    logic [63:0] want;
    logic [63:0] next_rem;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (crc_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected CRC word %h", out_tdata));
        end else begin
          want = crc_expected.pop_front();
          if (out_tdata !== want) begin
            report_mismatch($sformatf("crc_value %h, expected %h", out_tdata, want));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        next_rem = divide_byte(crc_remainder, in_tdata, shadow_degree, shadow_poly);
        if (in_tlast) begin
          crc_expected.push_back(next_rem);
          crc_remainder = '0;
        end else begin
          crc_remainder = next_rem;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off each time the token flips.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_stalls && $urandom_range(0, 99) < 20);
    end
  end

  // Watchdog on cycles in which no word and no register write is taken.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one byte, after an optional random gap, and waits until it is taken.
  task automatic send_word(input logic [7:0] data, input logic last);
    while (tx_gaps && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_message(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_word(8'($urandom), k == len - 1);
    end
  endtask

  // Stops offering and waits until every predicted CRC has arrived. The
  // first edge lets the predictor record the byte taken at the last one.
  task automatic wait_drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (crc_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that ends the access cycle.
  task automatic write_register(input logic reg_index, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({reg_index, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) begin
      @(posedge clk);
    end
    case (reg_index)
      REG_DEGREE: shadow_degree <= value[DEG_W-1:0];
      REG_POLY:   shadow_poly   <= value;
      default:    ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_generator(input logic [DEG_W-1:0] degree, input logic [63:0] poly);
    write_register(REG_DEGREE, 64'(degree));
    write_register(REG_POLY, poly);
  endtask

  // Reset generator (CRC-32, MSB first, no final XOR) on the check string.
  task automatic test_reset_crc32;
    string check_str;
    int    k;
    check_str = "123456789";
    for (k = 0; k < check_str.len(); k++) begin
      send_word(check_str[k], k == check_str.len() - 1);
    end
    wait_drain;
  endtask

  // Each listed generator, clamped degrees and polynomial bits above the degree.
  task automatic test_generator_extremes;
    int k;
    for (k = 0; k < 8; k++) begin
      set_generator(KNOWN_DEGREE[k], KNOWN_POLY[k]);
      send_word((k % 2 == 0) ? 8'hFF : 8'h00, 1'b1);
      wait_drain;
    end
    set_generator(DEG_W'(0), {64{1'b1}});
    send_word(8'h80, 1'b1);
    wait_drain;
    set_generator(DEG_W'(127), {64{1'b1}});
    send_word(8'hFF, 1'b1);
    wait_drain;
    set_generator(DEG_W'(65), 64'h800000000000000D);
    send_word(8'h01, 1'b1);
    wait_drain;
    set_generator(DEG_W'(8), 64'hFFFF_FFFF_FFFF_FFD3);
    send_word(8'hA5, 1'b1);
    wait_drain;
  endtask

  // The degree drops and then rises while a message is half done.
  task automatic test_midmessage_degree;
    set_generator(DEG_W'(64), 64'h800000000000000D);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b0);
    wait_drain;
    write_register(REG_DEGREE, 64'd8);
    send_word(8'h3C, 1'b0);
    wait_drain;
    write_register(REG_DEGREE, 64'd40);
    send_word(8'h81, 1'b1);
    wait_drain;
  endtask

  // The receiver holds off while short messages keep coming, so the
  // output word fills and the input side must stall.
  task automatic test_backpressure;
    int k;
    set_generator(DEG_W'(16), 64'h8810);
    tx_gaps    <= 1'b0;
    rx_stalls  <= 1'b0;
    hold_token <= ~hold_token;
    for (k = 0; k < 20; k++) begin
      send_message(3);
    end
    wait_drain;
  endtask

  task automatic set_random_config;
    logic [DEG_W-1:0] degree;
    logic [63:0]      poly;
    int               pick;
    case ($urandom_range(0, 4))
      0:       degree = CORNER_DEGREE[$urandom_range(0, 9)];
      1:       degree = DEG_W'($urandom_range(0, 127));
      default: degree = DEG_W'($urandom_range(1, 64));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      poly = KNOWN_POLY[$urandom_range(0, 7)];
    end else begin
      poly = {$urandom, $urandom};
    end
    pick = $urandom_range(0, 3);
    if (pick != 1) begin
      write_register(REG_DEGREE, 64'(degree));
    end
    if (pick != 0) begin
      write_register(REG_POLY, poly);
    end
  endtask

  // Random phases: new configuration, a few messages, and sometimes a
  // message left open to carry into the next phase. The middle quarter runs
  // with no gaps and no stalls.
  task automatic test_random_messages;
    int start_count;
    int count;
    int m;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      count = items_sent - start_count;
      tx_gaps   <= !(count >= 600 && count < 1000);
      rx_stalls <= !(count >= 600 && count < 1000);
      set_random_config;
      for (m = $urandom_range(3, 10); m > 0; m--) begin
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(1, 12));
      end
      if ($urandom_range(0, 3) == 0) begin
        for (m = $urandom_range(1, 5); m > 0; m--) begin
          send_word(8'($urandom), 1'b0);
        end
      end
      wait_drain;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_gaps   <= 1'b1;
    rx_stalls <= 1'b1;
    test_reset_crc32;
    test_generator_extremes;
    test_midmessage_degree;
    test_backpressure;
    test_random_messages;
    wait_drain;
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
